// ===== rtl/core/mvrp_pkg.sv =====
package mvrp_pkg;

   localparam int unsigned VERTEX_SLOTS_DEFAULT = 65536;
   localparam int unsigned LOCAL_BITS_DEFAULT   = 10;
   localparam int unsigned LIST_DEPTH_DEFAULT   = 1048576;

   localparam int VERTEX_W = 16;
   localparam int PACKED_W = 30;
   localparam int BASE_W   = 20;
   localparam int COUNT_W  = 11;

   localparam logic KIND_ENTRY    = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic [VERTEX_W-1:0] vertex_c;
      logic                meshlet_first;
      logic                meshlet_last;
   } tri_type;

   typedef struct packed {
      logic                kind;
      logic [VERTEX_W-1:0] global_vertex;
      logic [PACKED_W-1:0] packed_triangle;
      logic [BASE_W-1:0]   list_base;
      logic [COUNT_W-1:0]  local_count;
      logic                overflow;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } emit_type;

   // vertex index modulo slot count by restoring subtraction; the quotient
   // never exceeds 63 when the slot count is at least 1024
   function automatic logic [VERTEX_W-1:0] slot_of(input logic [VERTEX_W-1:0] vtx,
                                                   input int unsigned slots);
      logic [31:0] rem;
      rem = {16'b0, vtx};
      for (int k = 6; k >= 0; k--) begin
         if (rem >= (slots << k)) begin
            rem = rem - (slots << k);
         end
      end
      return rem[VERTEX_W-1:0];
   endfunction

endpackage

// ===== rtl/core/mvrp_ram.sv =====
module mvrp_ram #(
   parameter int unsigned WIDTH = 21,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/mvrp_remap_engine.sv =====
module mvrp_remap_engine #(
   parameter int unsigned VERTEX_SLOTS = mvrp_pkg::VERTEX_SLOTS_DEFAULT,
   parameter int unsigned LOCAL_BITS   = mvrp_pkg::LOCAL_BITS_DEFAULT,
   parameter int unsigned LIST_DEPTH   = mvrp_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  mvrp_pkg::tri_type  in_tri,
   output logic               take,
   input  logic               out_free,
   output mvrp_pkg::emit_type emit
);

   localparam int SLOT_W  = $clog2(VERTEX_SLOTS);
   localparam int POS_W   = $clog2(LIST_DEPTH);
   localparam int CNT_W   = LOCAL_BITS + 1;
   localparam int ENTRY_W = POS_W + 1;
   localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int TRI_W   = 3 * LOCAL_BITS;
   localparam int VTX_W   = mvrp_pkg::VERTEX_W;
   localparam int PACK_W  = mvrp_pkg::PACKED_W;
   localparam int BASE_W  = mvrp_pkg::BASE_W;
   localparam int COUNT_W = mvrp_pkg::COUNT_W;

   localparam logic [CNT_W-1:0]  LOCAL_MAX = CNT_W'(2 ** LOCAL_BITS);
   localparam logic [POS_W:0]    DEPTH_EXT = (POS_W + 1)'(LIST_DEPTH);
   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(LIST_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VERTEX_SLOTS - 1);

   typedef enum logic [4:0] {
      STEP_IDLE = 5'b00001,
      STEP_A    = 5'b00010,
      STEP_B    = 5'b00100,
      STEP_C    = 5'b01000,
      STEP_P    = 5'b10000
   } step_type;

   step_type            step_ff, step_in;
   logic [VTX_W-1:0]    vtx_a_ff, vtx_a_in, vtx_b_ff, vtx_b_in, vtx_c_ff, vtx_c_in;
   logic [SLOT_W-1:0]   slot_a_ff, slot_a_in, slot_b_ff, slot_b_in, slot_c_ff, slot_c_in;
   logic                first_ff, first_in, close_ff, close_in;
   logic [LOCAL_BITS-1:0] local_a_ff, local_a_in, local_b_ff, local_b_in;
   logic [LOCAL_BITS-1:0] local_c_ff, local_c_in;
   logic                ovf_ff, ovf_in;
   logic [POS_W-1:0]    base_ff, base_in, list_ff, list_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                open_ff, open_in;
   logic                clr_active_ff, clr_active_in;
   logic [SLOT_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0]   fwd_addr_ff, fwd_addr_in;
   logic [ENTRY_W-1:0]  fwd_data_ff, fwd_data_in;

   logic [VTX_W-1:0]    cur_vtx;
   logic [SLOT_W-1:0]   cur_slot;
   logic [ENTRY_W-1:0]  rdata, entry, wdata;
   logic [SLOT_W-1:0]   raddr, waddr;
   logic                we;
   logic                corner_step, opening, seen, full, is_new, corner_ovf;
   logic                emit_req, advance, finishing, load;
   logic [POS_W-1:0]    base_eff, offset, list_next;
   logic [CNT_W-1:0]    cnt_eff;
   logic [POS_W:0]      diff;
   logic [LOCAL_BITS-1:0] local_val;
   logic [TRI_W-1:0]    tri_bits;

   mvrp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VERTEX_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      unique case (step_ff)
         STEP_B: begin
            cur_vtx  = vtx_b_ff;
            cur_slot = slot_b_ff;
         end
         STEP_C: begin
            cur_vtx  = vtx_c_ff;
            cur_slot = slot_c_ff;
         end
         default: begin
            cur_vtx  = vtx_a_ff;
            cur_slot = slot_a_ff;
         end
      endcase
   end

   always_comb begin
      corner_step = (step_ff == STEP_A) || (step_ff == STEP_B) || (step_ff == STEP_C);
      opening     = (step_ff == STEP_A) && (first_ff || open_ff);
      base_eff    = opening ? list_ff : base_ff;
      cnt_eff     = opening ? '0 : cnt_ff;

      // the previous cycle's write is not yet visible at the read port
      entry  = (fwd_valid_ff && (fwd_addr_ff == cur_slot)) ? fwd_data_ff : rdata;
      diff   = {1'b0, entry[POS_W-1:0]} - {1'b0, base_eff};
      offset = diff[POS_W] ? POS_W'(diff + DEPTH_EXT) : diff[POS_W-1:0];
      seen   = entry[POS_W] && (CMP_W'(offset) < CMP_W'(cnt_eff));
      full   = (cnt_eff == LOCAL_MAX);

      is_new     = corner_step && !seen && !full;
      corner_ovf = corner_step && !seen && full;
      if (seen) begin
         local_val = LOCAL_BITS'(offset);
      end else if (full) begin
         local_val = '1;
      end else begin
         local_val = LOCAL_BITS'(cnt_eff);
      end

      list_next = (list_ff == POS_LAST) ? '0 : list_ff + POS_W'(1);

      emit_req  = is_new || (step_ff == STEP_C) || (step_ff == STEP_P);
      advance   = (corner_step || (step_ff == STEP_P)) && (!emit_req || out_free);
      finishing = advance && ((step_ff == STEP_P) || ((step_ff == STEP_C) && !is_new));
      load      = in_valid && !clr_active_ff && ((step_ff == STEP_IDLE) || finishing);
      take      = load;

      if (step_ff == STEP_C) begin
         tri_bits = {local_val, local_b_ff, local_a_ff};
      end else begin
         tri_bits = {local_c_ff, local_b_ff, local_a_ff};
      end

      emit.valid = advance && emit_req;
      if (is_new) begin
         emit.rsp.kind            = mvrp_pkg::KIND_ENTRY;
         emit.rsp.global_vertex   = cur_vtx;
         emit.rsp.packed_triangle = '0;
         emit.rsp.list_base       = BASE_W'(base_eff);
         emit.rsp.local_count     = COUNT_W'(cnt_eff + CNT_W'(1));
         emit.rsp.overflow        = 1'b0;
         emit.rsp.last            = 1'b0;
      end else begin
         emit.rsp.kind            = mvrp_pkg::KIND_TRIANGLE;
         emit.rsp.global_vertex   = '0;
         emit.rsp.packed_triangle = PACK_W'(tri_bits);
         emit.rsp.list_base       = BASE_W'(base_ff);
         emit.rsp.local_count     = COUNT_W'(cnt_ff);
         emit.rsp.overflow        = ovf_ff || corner_ovf;
         emit.rsp.last            = 1'b1;
      end

      if (clr_active_ff) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = '0;
      end else begin
         we    = advance && is_new;
         waddr = cur_slot;
         wdata = {1'b1, list_ff};
      end

      if (load) begin
         raddr = SLOT_W'(mvrp_pkg::slot_of(in_tri.vertex_a, VERTEX_SLOTS));
      end else if (advance && (step_ff == STEP_A)) begin
         raddr = slot_b_ff;
      end else if (advance && (step_ff == STEP_B)) begin
         raddr = slot_c_ff;
      end else begin
         raddr = cur_slot;
      end
   end

   always_comb begin
      step_in       = step_ff;
      vtx_a_in      = vtx_a_ff;
      vtx_b_in      = vtx_b_ff;
      vtx_c_in      = vtx_c_ff;
      slot_a_in     = slot_a_ff;
      slot_b_in     = slot_b_ff;
      slot_c_in     = slot_c_ff;
      first_in      = first_ff;
      close_in      = close_ff;
      local_a_in    = local_a_ff;
      local_b_in    = local_b_ff;
      local_c_in    = local_c_ff;
      ovf_in        = ovf_ff;
      base_in       = base_ff;
      list_in       = list_ff;
      cnt_in        = cnt_ff;
      open_in       = open_ff;
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      fwd_valid_in  = advance && is_new;
      fwd_addr_in   = cur_slot;
      fwd_data_in   = {1'b1, list_ff};

      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + SLOT_W'(1);
         if (clr_addr_ff == SLOT_LAST) begin
            clr_active_in = 1'b0;
         end
      end

      if (advance && corner_step) begin
         cnt_in  = is_new ? cnt_eff + CNT_W'(1) : cnt_eff;
         list_in = is_new ? list_next : list_ff;
      end

      if (advance) begin
         unique case (step_ff)
            STEP_A: begin
               base_in    = base_eff;
               open_in    = close_ff;
               local_a_in = local_val;
               ovf_in     = corner_ovf;
               step_in    = STEP_B;
            end
            STEP_B: begin
               local_b_in = local_val;
               ovf_in     = ovf_ff || corner_ovf;
               step_in    = STEP_C;
            end
            STEP_C: begin
               local_c_in = local_val;
               ovf_in     = ovf_ff || corner_ovf;
               step_in    = is_new ? STEP_P : STEP_IDLE;
            end
            default: begin
               step_in = STEP_IDLE;
            end
         endcase
      end

      if (load) begin
         step_in   = STEP_A;
         vtx_a_in  = in_tri.vertex_a;
         vtx_b_in  = in_tri.vertex_b;
         vtx_c_in  = in_tri.vertex_c;
         slot_a_in = SLOT_W'(mvrp_pkg::slot_of(in_tri.vertex_a, VERTEX_SLOTS));
         slot_b_in = SLOT_W'(mvrp_pkg::slot_of(in_tri.vertex_b, VERTEX_SLOTS));
         slot_c_in = SLOT_W'(mvrp_pkg::slot_of(in_tri.vertex_c, VERTEX_SLOTS));
         first_in  = in_tri.meshlet_first;
         close_in  = in_tri.meshlet_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         base_ff       <= '0;
         list_ff       <= '0;
         cnt_ff        <= '0;
         open_ff       <= 1'b1;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         base_ff       <= base_in;
         list_ff       <= list_in;
         cnt_ff        <= cnt_in;
         open_ff       <= open_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
      vtx_a_ff    <= vtx_a_in;
      vtx_b_ff    <= vtx_b_in;
      vtx_c_ff    <= vtx_c_in;
      slot_a_ff   <= slot_a_in;
      slot_b_ff   <= slot_b_in;
      slot_c_ff   <= slot_c_in;
      first_ff    <= first_in;
      close_ff    <= close_in;
      local_a_ff  <= local_a_in;
      local_b_ff  <= local_b_in;
      local_c_ff  <= local_c_in;
      ovf_ff      <= ovf_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

`ifndef SYNTHESIS
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (step_ff == STEP_IDLE))
      else $error("triangle started during slot clearing pass");

   a_counter_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LOCAL_MAX)
      else $error("local counter beyond local index range");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result emitted into occupied output register");

   a_kind_marks_last: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (emit.rsp.kind == emit.rsp.last))
      else $error("packed triangle and last flag disagree");

   a_no_fwd_after_clear: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> !clr_active_ff)
      else $error("forwarded write during clearing pass");
`endif

endmodule

// ===== rtl/core/meshlet_vertex_remap_packer.sv =====
// Meshlet vertex remap and triangle packer.
// req_ channel: one triangle per transaction, three global vertex indices plus
// meshlet_first / meshlet_last flags. rsp_ channel: per triangle, one
// global-list entry (kind 0) for each corner new to the meshlet and not in
// overflow, in corner order, then the packed local indices (kind 1, last set).
// The remap engine runs steps A, B and C per triangle, one read-modify-write of
// the vertex slot RAM per corner, plus step P when its third corner is new,
// since the packed result then needs its own turn on the result register.
// Reset starts a clearing pass over all VERTEX_SLOTS slots of the slot RAM, one
// slot a cycle; one request is buffered meanwhile and no triangle starts.
// A stalled receiver holds the result register; the engine stops at the next
// corner that produces a result and the input buffer then fills and drops
// req_ready.
module meshlet_vertex_remap_packer #(
   parameter int unsigned VERTEX_SLOTS = mvrp_pkg::VERTEX_SLOTS_DEFAULT,
   parameter int unsigned LOCAL_BITS   = mvrp_pkg::LOCAL_BITS_DEFAULT,
   parameter int unsigned LIST_DEPTH   = mvrp_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_vertex_a,
   input  logic [15:0] req_vertex_b,
   input  logic [15:0] req_vertex_c,
   input  logic        req_meshlet_first,
   input  logic        req_meshlet_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_global_vertex,
   output logic [29:0] rsp_packed_triangle,
   output logic [19:0] rsp_list_base,
   output logic [10:0] rsp_local_count,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   logic               in_valid_ff, in_valid_in;
   mvrp_pkg::tri_type  in_tri_ff, in_tri_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mvrp_pkg::rsp_type  rsp_ff, rsp_in;
   logic               take, out_free, req_accept;
   mvrp_pkg::emit_type emit;

   mvrp_remap_engine #(
      .VERTEX_SLOTS (VERTEX_SLOTS),
      .LOCAL_BITS   (LOCAL_BITS),
      .LIST_DEPTH   (LIST_DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_tri   (in_tri_ff),
      .take     (take),
      .out_free (out_free),
      .emit     (emit)
   );

   always_comb begin
      req_ready  = !in_valid_ff || take;
      req_accept = req_valid && req_ready;
      out_free   = !rsp_valid_ff || rsp_ready;

      in_valid_in = in_valid_ff;
      in_tri_in   = in_tri_ff;
      if (req_accept) begin
         in_valid_in             = 1'b1;
         in_tri_in.vertex_a      = req_vertex_a;
         in_tri_in.vertex_b      = req_vertex_b;
         in_tri_in.vertex_c      = req_vertex_c;
         in_tri_in.meshlet_first = req_meshlet_first;
         in_tri_in.meshlet_last  = req_meshlet_last;
      end else if (take) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_tri_ff <= in_tri_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_global_vertex   = rsp_ff.global_vertex;
   assign rsp_packed_triangle = rsp_ff.packed_triangle;
   assign rsp_list_base       = rsp_ff.list_base;
   assign rsp_local_count     = rsp_ff.local_count;
   assign rsp_overflow        = rsp_ff.overflow;
   assign rsp_last            = rsp_ff.last;

endmodule
